/* design/btq_pkg.sv */
// Shared types and sizing constants for the buzzer tone queue sequencer.
// Used by every module of the block; no dependencies of its own.
package btq_pkg;

   // Queue sizing
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Request codes
   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_TICK    = 1'b1;
   localparam logic PORT_ONE     = 1'b0;
   localparam logic PORT_TWO     = 1'b1;

   // One stored tone command (60 bits)
   typedef struct packed {
      logic        port;
      logic [7:0]  pins;
      logic [15:0] period;
      logic [15:0] duty;
      logic [15:0] length;
      logic [1:0]  cmode;
      logic        check;
   } cmd_type;

   // One request as held in the input register
   typedef struct packed {
      logic    mode;
      cmd_type cmd;
      logic    finish_answer;
   } req_type;

   // Queue update commands from the tone controller
   typedef struct packed {
      logic        push;
      logic        pop;
      logic        upd_len;
      logic [15:0] new_len;
   } fifo_ctrl_type;

   // Queue status toward the tone controller
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             full;
      logic             empty;
   } fifo_stat_type;

   // One result as held in the output register
   typedef struct packed {
      logic [7:0]  p1_select;
      logic [7:0]  p2_select;
      logic [15:0] period_out;
      logic [15:0] duty_out;
      logic [1:0]  mode_out;
      logic        tone_started;
      logic        tone_stopped;
      logic [3:0]  queue_count;
      logic        dropped;
   } rsp_type;

endpackage

/* design/btq_in_stage.sv */
// Input register of the buzzer tone queue sequencer.
// Depends on btq_pkg for the request struct.
module btq_in_stage import btq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   input  logic    take,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff, valid_in;
   req_type item_ff;

   // Free when empty or when the held request moves on this cycle
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload capture
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* design/btq_cmd_fifo.sv */
// Command FIFO: register store, head and tail pointers, fill count.
// Depends on btq_pkg for sizing and struct types.
module btq_cmd_fifo import btq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       push_cmd,
   input  fifo_ctrl_type ctrl,
   output cmd_type       head_cmd,
   output fifo_stat_type stat
);

   cmd_type          store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PTR_W'(1);
   endfunction

   // Pointer and count update
   always_comb begin
      head_in  = ctrl.pop  ? next_ptr(head_ff) : head_ff;
      tail_in  = ctrl.push ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff;
      if (ctrl.push && !ctrl.pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store writes: append at tail, remaining length rewritten at head
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         store_ff[tail_ff] <= push_cmd;
      end
      if (ctrl.upd_len) begin
         store_ff[head_ff].length <= ctrl.new_len;
      end
   end

   assign head_cmd   = store_ff[head_ff];
   assign stat.count = count_ff;
   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

/* design/btq_tone_ctrl.sv */
// Tone controller: head end/start decisions, timer registers, result register.
// Depends on btq_pkg; drives btq_cmd_fifo through fifo_ctrl_type.
module btq_tone_ctrl import btq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  req_type       item,
   output logic          take,
   input  cmd_type       head_cmd,
   input  fifo_stat_type stat,
   output fifo_ctrl_type ctrl,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp
);

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        running_ff, running_in;
   logic [7:0]  p1_ff, p1_in;
   logic [7:0]  p2_ff, p2_in;
   logic [15:0] period_ff, period_in;
   logic [15:0] duty_ff, duty_in;
   logic [1:0]  cmode_ff, cmode_in;

   logic             is_tick, ends, started, stopped, drop;
   logic             len_neg, len_zero, duty_pos;
   logic [CNT_W-1:0] count_after;
   logic [CNT_W+3:0] count_wide;

   // A request moves on when the result register is free or being taken
   assign take = item_valid && (!rsp_valid_ff || rsp_ready);

   assign is_tick  = (item.mode == MODE_TICK);
   assign len_neg  = head_cmd.length[15];
   assign len_zero = (head_cmd.length == 16'd0);
   assign duty_pos = !head_cmd.duty[15] && (head_cmd.duty != 16'd0);

   // Head end rule
   assign ends = (len_neg && head_cmd.check && !item.finish_answer) ||
                 (!head_cmd.check && (len_neg || len_zero));

   // Decisions and next timer state
   always_comb begin
      ctrl         = '0;
      ctrl.new_len = head_cmd.length - 16'd1;
      started      = 1'b0;
      stopped      = 1'b0;
      drop         = 1'b0;
      running_in   = running_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      period_in    = period_ff;
      duty_in      = duty_ff;
      cmode_in     = cmode_ff;
      if (take) begin
         if (!is_tick) begin
            drop      = stat.full;
            ctrl.push = !stat.full;
         end else if (!stat.empty) begin
            if (ends) begin
               ctrl.pop   = 1'b1;
               stopped    = 1'b1;
               running_in = 1'b0;
               if (head_cmd.port == PORT_TWO) begin
                  p2_in = p2_ff & ~head_cmd.pins;
               end else begin
                  p1_in = p1_ff & ~head_cmd.pins;
               end
            end else begin
               if (!running_ff) begin
                  started    = 1'b1;
                  running_in = 1'b1;
                  if (head_cmd.port == PORT_TWO) begin
                     p2_in = p2_ff | head_cmd.pins;
                  end else begin
                     p1_in = p1_ff | head_cmd.pins;
                  end
                  period_in = head_cmd.period;
                  cmode_in  = head_cmd.cmode;
                  if (duty_pos) begin
                     duty_in = head_cmd.duty;
                  end
               end
               ctrl.upd_len = !len_neg && !len_zero;
            end
         end
      end
   end

   // Fill count after this request, reported in four bits
   always_comb begin
      count_after = stat.count;
      if (ctrl.push) begin
         count_after = stat.count + CNT_W'(1);
      end else if (ctrl.pop) begin
         count_after = stat.count - CNT_W'(1);
      end
      count_wide = {4'b0000, count_after};
   end

   // Result assembly
   always_comb begin
      rsp_in.p1_select    = p1_in;
      rsp_in.p2_select    = p2_in;
      rsp_in.period_out   = period_in;
      rsp_in.duty_out     = duty_in;
      rsp_in.mode_out     = cmode_in;
      rsp_in.tone_started = started;
      rsp_in.tone_stopped = stopped;
      rsp_in.queue_count  = count_wide[3:0];
      rsp_in.dropped      = drop;
      rsp_valid_in        = take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         running_ff   <= 1'b0;
         p1_ff        <= '0;
         p2_ff        <= '0;
         period_ff    <= '0;
         duty_ff      <= '0;
         cmode_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         running_ff   <= running_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         period_ff    <= period_in;
         duty_ff      <= duty_in;
         cmode_ff     <= cmode_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* design/buzzer_tone_queue_sequencer.sv */
// Buzzer tone queue sequencer: a queue of tone commands driving one tone timer.
// Request channel (req_*): mode 0 appends a command, mode 1 is a scheduler tick.
// Result channel (rsp_*): one result per request with the timer registers,
// pin selects, start/stop flags, queue fill and a drop flag for a full queue.
// Both channels use valid/ready; a request or result moves when both are high.
// An accepted request sits in the input register, then loads the result register
// once that register is free or being taken (rsp_valid rises with it), and can
// then be taken on the result channel.
// Throughput: one request per cycle while rsp_ready holds; the head command is read
// from a register store and the decision is a short compare and 16-bit decrement.
// When the receiver stalls, the result register holds and an empty input register
// still takes one more request; req_ready then drops until results drain.
// Reset (synchronous, active high) empties the queue and clears the pin selects,
// period, duty, count mode and running flag; store contents are not cleared.
// Depends on btq_pkg, btq_in_stage, btq_cmd_fifo and btq_tone_ctrl.
module buzzer_tone_queue_sequencer import btq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic               req_port_sel,
   input  logic [7:0]         req_pin_mask,
   input  logic [15:0]        req_tone_period,
   input  logic signed [15:0] req_tone_duty,
   input  logic signed [15:0] req_tone_length,
   input  logic [1:0]         req_count_mode,
   input  logic               req_has_finish_check,
   input  logic               req_finish_answer,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_p1_select,
   output logic [7:0]         rsp_p2_select,
   output logic [15:0]        rsp_period_out,
   output logic [15:0]        rsp_duty_out,
   output logic [1:0]         rsp_mode_out,
   output logic               rsp_tone_started,
   output logic               rsp_tone_stopped,
   output logic [3:0]         rsp_queue_count,
   output logic               rsp_dropped
);

   req_type       req_item, item;
   logic          item_valid, take;
   cmd_type       head_cmd;
   fifo_stat_type stat;
   fifo_ctrl_type ctrl;
   rsp_type       rsp;

   // Pack the request ports
   assign req_item.mode          = req_mode;
   assign req_item.cmd.port      = req_port_sel;
   assign req_item.cmd.pins      = req_pin_mask;
   assign req_item.cmd.period    = req_tone_period;
   assign req_item.cmd.duty      = req_tone_duty;
   assign req_item.cmd.length    = req_tone_length;
   assign req_item.cmd.cmode     = req_count_mode;
   assign req_item.cmd.check     = req_has_finish_check;
   assign req_item.finish_answer = req_finish_answer;

   btq_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   btq_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_cmd (item.cmd),
      .ctrl     (ctrl),
      .head_cmd (head_cmd),
      .stat     (stat)
   );

   btq_tone_ctrl u_tone_ctrl (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .head_cmd   (head_cmd),
      .stat       (stat),
      .ctrl       (ctrl),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // Unpack the result register
   assign rsp_p1_select    = rsp.p1_select;
   assign rsp_p2_select    = rsp.p2_select;
   assign rsp_period_out   = rsp.period_out;
   assign rsp_duty_out     = rsp.duty_out;
   assign rsp_mode_out     = rsp.mode_out;
   assign rsp_tone_started = rsp.tone_started;
   assign rsp_tone_stopped = rsp.tone_stopped;
   assign rsp_queue_count  = rsp.queue_count;
   assign rsp_dropped      = rsp.dropped;

endmodule

/* test/btq_checker.sv */
`timescale 1ns / 1ps
// Checker for the buzzer tone queue sequencer: watches the request and result channels,
// predicts every result from its own copy of the queue and timer registers, compares.
// Depends on btq_pkg for the command, request and result types.
module btq_checker import btq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_mode,
   input  logic        req_port_sel,
   input  logic [7:0]  req_pin_mask,
   input  logic [15:0] req_tone_period,
   input  logic [15:0] req_tone_duty,
   input  logic [15:0] req_tone_length,
   input  logic [1:0]  req_count_mode,
   input  logic        req_has_finish_check,
   input  logic        req_finish_answer,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_p1_select,
   input  logic [7:0]  rsp_p2_select,
   input  logic [15:0] rsp_period_out,
   input  logic [15:0] rsp_duty_out,
   input  logic [1:0]  rsp_mode_out,
   input  logic        rsp_tone_started,
   input  logic        rsp_tone_stopped,
   input  logic [3:0]  rsp_queue_count,
   input  logic        rsp_dropped,
   output int          mismatch_count,
   output int          pending_results
);

   // Shadow of the command queue and the tone timer registers
   cmd_type     tone_store [QUEUE_DEPTH];
   int          head_idx;
   int          tail_idx;
   int          fill;
   logic        running;
   logic [7:0]  port1_pins;
   logic [7:0]  port2_pins;
   logic [15:0] period_q;
   logic [15:0] duty_q;
   logic [1:0]  cmode_q;

   rsp_type     expected_tone_q [$];
   int          result_idx;

   task automatic report_mismatch(input string what);
      $display("ERROR: result %0d: %s", result_idx, what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
   endtask

   // Applies one request to the shadow state and returns the result it causes
   function automatic rsp_type predict_tone_result(input req_type r);
      rsp_type res;
      cmd_type head;
      logic    ends;
      res = '0;
      if (r.mode == MODE_ENQUEUE) begin
         if (fill >= QUEUE_DEPTH) begin
            res.dropped = 1'b1;
         end else begin
            tone_store[tail_idx] = r.cmd;
            tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
            fill++;
         end
      end else if (fill > 0) begin
         head = tone_store[head_idx];
         ends = ($signed(head.length) < 0 && head.check && !r.finish_answer) ||
                (!head.check && $signed(head.length) <= 0);
         if (ends) begin
            // stop: deselect pins and pop
            if (head.port == PORT_TWO) port2_pins = port2_pins & ~head.pins;
            else port1_pins = port1_pins & ~head.pins;
            head_idx = (head_idx + 1) % QUEUE_DEPTH;
            fill--;
            running = 1'b0;
            res.tone_stopped = 1'b1;
         end else begin
            if (!running) begin
               running = 1'b1;
               if (head.port == PORT_TWO) port2_pins = port2_pins | head.pins;
               else port1_pins = port1_pins | head.pins;
               period_q = head.period;
               if ($signed(head.duty) > 0) duty_q = head.duty;
               cmode_q = head.cmode;
               res.tone_started = 1'b1;
            end
            if ($signed(head.length) > 0)
               tone_store[head_idx].length = head.length - 16'd1;
         end
      end
      res.p1_select   = port1_pins;
      res.p2_select   = port2_pins;
      res.period_out  = period_q;
      res.duty_out    = duty_q;
      res.mode_out    = cmode_q;
      res.queue_count = fill[3:0];
      return res;
   endfunction

   // Results are checked before the request of the same edge is predicted
   always @(posedge clock) begin : watch
      req_type accepted;
      rsp_type seen;
      rsp_type want;
      if (reset) begin
         head_idx   = 0;
         tail_idx   = 0;
         fill       = 0;
         running    = 1'b0;
         port1_pins = '0;
         port2_pins = '0;
         period_q   = '0;
         duty_q     = '0;
         cmode_q    = '0;
         expected_tone_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.p1_select    = rsp_p1_select;
            seen.p2_select    = rsp_p2_select;
            seen.period_out   = rsp_period_out;
            seen.duty_out     = rsp_duty_out;
            seen.mode_out     = rsp_mode_out;
            seen.tone_started = rsp_tone_started;
            seen.tone_stopped = rsp_tone_stopped;
            seen.queue_count  = rsp_queue_count;
            seen.dropped      = rsp_dropped;
            if (expected_tone_q.size() == 0) begin
               report_mismatch("result arrived with nothing expected");
            end else begin
               want = expected_tone_q.pop_front();
               compare_field("p1_select", 16'(seen.p1_select), 16'(want.p1_select));
               compare_field("p2_select", 16'(seen.p2_select), 16'(want.p2_select));
               compare_field("period_out", seen.period_out, want.period_out);
               compare_field("duty_out", seen.duty_out, want.duty_out);
               compare_field("mode_out", 16'(seen.mode_out), 16'(want.mode_out));
               compare_field("tone_started", 16'(seen.tone_started),
                             16'(want.tone_started));
               compare_field("tone_stopped", 16'(seen.tone_stopped),
                             16'(want.tone_stopped));
               compare_field("queue_count", 16'(seen.queue_count),
                             16'(want.queue_count));
               compare_field("dropped", 16'(seen.dropped), 16'(want.dropped));
            end
            result_idx++;
         end
         if (req_valid && req_ready) begin
            accepted.mode          = req_mode;
            accepted.cmd.port      = req_port_sel;
            accepted.cmd.pins      = req_pin_mask;
            accepted.cmd.period    = req_tone_period;
            accepted.cmd.duty      = req_tone_duty;
            accepted.cmd.length    = req_tone_length;
            accepted.cmd.cmode     = req_count_mode;
            accepted.cmd.check     = req_has_finish_check;
            accepted.finish_answer = req_finish_answer;
            expected_tone_q.push_back(predict_tone_result(accepted));
         end
      end
      pending_results = expected_tone_q.size();
   end

endmodule

/* test/buzzer_tone_queue_sequencer_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the buzzer tone queue sequencer: clock, reset, request
// stimulus, result-side stalls, watchdog and verdict. Depends on btq_pkg, btq_checker.
module buzzer_tone_queue_sequencer_tb;
   import btq_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_LIMIT = 500;
   localparam int RANDOM_REQS = 1020;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = MODE_TICK;
   logic               req_port_sel = PORT_ONE;
   logic [7:0]         req_pin_mask = '0;
   logic [15:0]        req_tone_period = '0;
   logic signed [15:0] req_tone_duty = '0;
   logic signed [15:0] req_tone_length = '0;
   logic [1:0]         req_count_mode = '0;
   logic               req_has_finish_check = 1'b0;
   logic               req_finish_answer = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [7:0]         rsp_p1_select;
   logic [7:0]         rsp_p2_select;
   logic [15:0]        rsp_period_out;
   logic [15:0]        rsp_duty_out;
   logic [1:0]         rsp_mode_out;
   logic               rsp_tone_started;
   logic               rsp_tone_stopped;
   logic [3:0]         rsp_queue_count;
   logic               rsp_dropped;

   int                 mismatch_count;
   int                 pending_results;
   bit                 steady = 1'b0;   // no idling on either side
   int                 hold_len = 0;    // receiver hold-off request, in cycles
   int                 stall_cycles = 0;

   always #5 clock = ~clock;

   buzzer_tone_queue_sequencer u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_port_sel         (req_port_sel),
      .req_pin_mask         (req_pin_mask),
      .req_tone_period      (req_tone_period),
      .req_tone_duty        (req_tone_duty),
      .req_tone_length      (req_tone_length),
      .req_count_mode       (req_count_mode),
      .req_has_finish_check (req_has_finish_check),
      .req_finish_answer    (req_finish_answer),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_p1_select        (rsp_p1_select),
      .rsp_p2_select        (rsp_p2_select),
      .rsp_period_out       (rsp_period_out),
      .rsp_duty_out         (rsp_duty_out),
      .rsp_mode_out         (rsp_mode_out),
      .rsp_tone_started     (rsp_tone_started),
      .rsp_tone_stopped     (rsp_tone_stopped),
      .rsp_queue_count      (rsp_queue_count),
      .rsp_dropped          (rsp_dropped)
   );

   btq_checker u_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_port_sel         (req_port_sel),
      .req_pin_mask         (req_pin_mask),
      .req_tone_period      (req_tone_period),
      .req_tone_duty        (req_tone_duty),
      .req_tone_length      (req_tone_length),
      .req_count_mode       (req_count_mode),
      .req_has_finish_check (req_has_finish_check),
      .req_finish_answer    (req_finish_answer),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_p1_select        (rsp_p1_select),
      .rsp_p2_select        (rsp_p2_select),
      .rsp_period_out       (rsp_period_out),
      .rsp_duty_out         (rsp_duty_out),
      .rsp_mode_out         (rsp_mode_out),
      .rsp_tone_started     (rsp_tone_started),
      .rsp_tone_stopped     (rsp_tone_stopped),
      .rsp_queue_count      (rsp_queue_count),
      .rsp_dropped          (rsp_dropped),
      .mismatch_count       (mismatch_count),
      .pending_results      (pending_results)
   );

   function automatic req_type enqueue_item(logic port, logic [7:0] pins,
                                            logic [15:0] period, logic [15:0] duty,
                                            logic [15:0] length, logic [1:0] cmode,
                                            logic check);
      req_type r;
      r.mode          = MODE_ENQUEUE;
      r.cmd.port      = port;
      r.cmd.pins      = pins;
      r.cmd.period    = period;
      r.cmd.duty      = duty;
      r.cmd.length    = length;
      r.cmd.cmode     = cmode;
      r.cmd.check     = check;
      r.finish_answer = 1'($urandom_range(1));   // ignored on enqueue
      return r;
   endfunction

   // Tick with random content in the command fields, which a tick ignores
   function automatic req_type tick_item(logic answer);
      req_type     r;
      logic [63:0] noise;
      noise           = {$urandom, $urandom};
      r.mode          = MODE_TICK;
      r.cmd           = noise[59:0];
      r.finish_answer = answer;
      return r;
   endfunction

   // Offer one request, hold it until accepted, then maybe idle a while
   task automatic send_item(input req_type r);
      req_valid            <= 1'b1;
      req_mode             <= r.mode;
      req_port_sel         <= r.cmd.port;
      req_pin_mask         <= r.cmd.pins;
      req_tone_period      <= r.cmd.period;
      req_tone_duty        <= r.cmd.duty;
      req_tone_length      <= r.cmd.length;
      req_count_mode       <= r.cmd.cmode;
      req_has_finish_check <= r.cmd.check;
      req_finish_answer    <= r.finish_answer;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      while (!steady && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Result side: random stalls, quiet stretch, and a long hold-off on request
   initial begin : sink
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len - 1) @(posedge clock);
            hold_len = 0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 22);
         end
      end
   end

   // Watchdog: cycles in a row with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      int          k;
      int          enq_pct;
      int          drain;
      logic        chk;
      logic [15:0] len;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ticks on an empty queue change nothing
      send_item(tick_item(1'b0));
      send_item(tick_item(1'b1));
      // counted tone, all-ones pins, period and mode, largest duty: start, count down, stop
      send_item(enqueue_item(PORT_ONE, 8'hFF, 16'hFFFF, 16'h7FFF, 16'd2, 2'd3, 1'b0));
      send_item(tick_item(1'b1));
      send_item(tick_item(1'b0));
      send_item(tick_item(1'b1));
      // checked tone with most negative length and duty: runs until answer is 0
      send_item(enqueue_item(PORT_TWO, 8'hAA, 16'h0000, 16'h8000, 16'h8000, 2'd0, 1'b1));
      send_item(tick_item(1'b1));
      send_item(tick_item(1'b1));
      send_item(tick_item(1'b0));
      // zero length, length -1, zero duty, duty 1, duty -1, length 1
      send_item(enqueue_item(PORT_ONE, 8'h55, 16'h1234, 16'h0000, 16'h0000, 2'd1, 1'b0));
      send_item(enqueue_item(PORT_TWO, 8'hFF, 16'h8000, 16'h0001, 16'hFFFF, 2'd2, 1'b0));
      send_item(enqueue_item(PORT_ONE, 8'h0F, 16'h00FF, 16'hFFFF, 16'h0001, 2'd3, 1'b0));
      repeat (4) send_item(tick_item(1'($urandom_range(1))));
      // overfill: the last enqueue is dropped
      repeat (QUEUE_DEPTH + 1)
         send_item(enqueue_item(1'($urandom), 8'($urandom), 16'($urandom),
                                16'($urandom), 16'hFFFF, 2'($urandom), 1'b0));

      // Random traffic, alternating between filling and draining phases
      for (k = 0; k < RANDOM_REQS; k++) begin
         if (k == 300) hold_len = 60;
         if (k == 600) begin
            req_valid <= 1'b0;
            while (pending_results != 0) @(negedge clock);
            @(posedge clock);
         end
         steady  = (k >= 700 && k < 850);
         enq_pct = ((k / 100) % 2 != 0) ? 20 : 45;
         if ($urandom_range(99) < enq_pct) begin
            // a checked command must have a negative length or it never ends
            chk = ($urandom_range(99) < 35);
            if (chk || $urandom_range(9) == 0)
               len = {1'b1, 15'($urandom)};
            else
               len = 16'($urandom_range(8)) - 16'd2;
            send_item(enqueue_item(1'($urandom), 8'($urandom), 16'($urandom),
                                   16'($urandom), len, 2'($urandom), chk));
         end else begin
            send_item(tick_item($urandom_range(99) < 60));
         end
      end
      steady = 1'b0;

      // Checked commands with nonnegative length never end: the queue jams and drops
      send_item(enqueue_item(PORT_TWO, 8'($urandom), 16'($urandom), 16'($urandom),
                             16'h0000, 2'($urandom), 1'b1));
      send_item(enqueue_item(PORT_ONE, 8'($urandom), 16'($urandom), 16'($urandom),
                             16'h7FFF, 2'($urandom), 1'b1));
      repeat (40) send_item(tick_item(1'($urandom_range(1))));
      repeat (QUEUE_DEPTH + 2)
         send_item(enqueue_item(1'($urandom), 8'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom), 2'($urandom),
                                1'($urandom)));
      req_valid <= 1'b0;

      // Drain, then a few quiet cycles for stray results
      drain = 0;
      while (pending_results != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (4) @(negedge clock);
      if (pending_results != 0)
         $display("ERROR: %0d expected results never arrived", pending_results);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
